// ----- rtl/core/shared_pool_multi_queue_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Shared pool multi queue assertion macros
// Concurrent assertion wrappers used by the checker of the shared pool unit.
// ----------------------------------------------------------------------------
`ifndef SHARED_POOL_MULTI_QUEUE_UNIT_MACROS_SVH
`define SHARED_POOL_MULTI_QUEUE_UNIT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define SPMQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Assertion on the default clock and reset of the unit.
`define SPMQ_ASSERT(label, prop, msg) \
  `SPMQ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/core/spmq_pkg.sv -----
// ----------------------------------------------------------------------------
// Shared pool multi queue package
// Widths, defaults, state codes and the command type shared by the unit.
// ----------------------------------------------------------------------------
package spmq_pkg;

  localparam int unsigned QID_W           = 3;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned POOL_NODES_DEF  = 64;
  localparam int unsigned QUEUE_COUNT_DEF = 8;
  localparam int unsigned CMD_FIFO_DEPTH  = 2;
  // Command queue, the command in the back end and the response register.
  localparam int unsigned MAX_OUTSTANDING = CMD_FIFO_DEPTH + 2;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_kind_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PUT,
    BK_GET_LINK,
    BK_GET_DONE,
    BK_FAIL
  } bk_state_e;

  typedef struct packed {
    op_kind_e              kind;
    logic                  in_range;
    logic [QID_W-1:0]      queue_id;
    logic [WORD_W-1:0]     data_word;
  } spmq_cmd_t;

endpackage

// ----- rtl/core/spmq_if.sv -----
// ----------------------------------------------------------------------------
// Shared pool multi queue channels
// Valid/ready request and response channels of the shared pool unit.
// ----------------------------------------------------------------------------
interface spmq_req_if import spmq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [QID_W-1:0]  queue_id;
  logic [WORD_W-1:0] data_word;

  modport source (output valid, output kind, output queue_id, output data_word, input ready);
  modport sink (input valid, input kind, input queue_id, input data_word, output ready);
endinterface

interface spmq_rsp_if import spmq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [WORD_W-1:0] read_word;

  modport source (output valid, output ok, output read_word, input ready);
  modport sink (input valid, input ok, input read_word, output ready);
endinterface

// ----- rtl/core/spmq_front.sv -----
// ----------------------------------------------------------------------------
// Shared pool multi queue front end
// Accepts request beats, checks the queue index and buffers the commands.
// ----------------------------------------------------------------------------
module spmq_front import spmq_pkg::*; #(
  parameter int unsigned QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spmq_req_if.sink   req_i,
  output logic       cmd_valid_o,
  output spmq_cmd_t  cmd_o,
  input  logic       cmd_pop_i
);

  localparam int unsigned PtrW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(CMD_FIFO_DEPTH + 1);
  localparam int unsigned CmpW = ($clog2(QUEUE_COUNT + 1) > QID_W) ?
                                 $clog2(QUEUE_COUNT + 1) : QID_W;

  spmq_cmd_t         fifo_q [CMD_FIFO_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push;
  logic              pop;
  spmq_cmd_t         in_cmd;

  assign req_i.ready = (count_q != CntW'(CMD_FIFO_DEPTH));
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    in_cmd.kind      = op_kind_e'(req_i.kind);
    in_cmd.in_range  = (CmpW'(req_i.queue_id) < CmpW'(QUEUE_COUNT));
    in_cmd.queue_id  = req_i.queue_id;
    in_cmd.data_word = req_i.data_word;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_cmd;
    end
  end

endmodule

// ----- rtl/core/spmq_back.sv -----
// ----------------------------------------------------------------------------
// Shared pool multi queue back end
// Sequencer over the link, word, head and tail memories with a response
// register on the output channel.
// ----------------------------------------------------------------------------
module spmq_back import spmq_pkg::*; #(
  parameter int unsigned POOL_NODES  = POOL_NODES_DEF,
  parameter int unsigned QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  spmq_cmd_t  cmd_i,
  output logic       cmd_pop_o,
  spmq_rsp_if.source rsp_o
);

  localparam int unsigned NodeW = $clog2(POOL_NODES);
  localparam int unsigned CntW  = $clog2(POOL_NODES + 1);
  localparam int unsigned QIdxW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  bk_state_e          state_q, state_d;
  spmq_cmd_t          cmd_q;
  logic [NodeW-1:0]   free_head_q, free_head_d;
  logic [CntW-1:0]    free_cnt_q, free_cnt_d;
  logic [CntW-1:0]    fresh_cnt_q, fresh_cnt_d;
  logic [QUEUE_COUNT-1:0] qvalid_q, qvalid_d;
  logic               out_valid_q, out_valid_d;
  logic               out_ok_q, out_ok_d;
  logic [WORD_W-1:0]  out_word_q, out_word_d;

  logic [NodeW-1:0]   link_mem [POOL_NODES];
  logic [WORD_W-1:0]  word_mem [POOL_NODES];
  logic [NodeW-1:0]   qhead_mem [QUEUE_COUNT];
  logic [NodeW-1:0]   qtail_mem [QUEUE_COUNT];
  logic [NodeW-1:0]   link_rd_q;
  logic [WORD_W-1:0]  word_rd_q;
  logic [NodeW-1:0]   qhead_rd_q;
  logic [NodeW-1:0]   qtail_rd_q;

  logic               pop;
  logic               out_free;
  logic               emit;
  logic               pool_avail;
  logic               in_fail;
  logic [QIdxW-1:0]   in_qidx;
  logic [QIdxW-1:0]   cur_qidx;
  logic [NodeW-1:0]   alloc_node;

  logic               link_re, link_we;
  logic [NodeW-1:0]   link_raddr, link_waddr, link_wdata;
  logic               word_re, word_we;
  logic [NodeW-1:0]   word_raddr, word_waddr;
  logic               q_re;
  logic               qhead_we, qtail_we;
  logic [NodeW-1:0]   qhead_wdata;

  assign in_qidx    = QIdxW'(cmd_i.queue_id);
  assign cur_qidx   = QIdxW'(cmd_q.queue_id);
  assign pool_avail = (free_cnt_q != '0) || (fresh_cnt_q != CntW'(POOL_NODES));
  assign alloc_node = (free_cnt_q != '0) ? free_head_q : NodeW'(fresh_cnt_q);
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign pop        = (state_q == BK_IDLE) && cmd_valid_i;
  assign cmd_pop_o  = pop;

  always_comb begin
    in_fail = 1'b1;
    if (cmd_i.in_range) begin
      if (cmd_i.kind == OP_PUT) begin
        in_fail = !pool_avail;
      end else begin
        in_fail = !qvalid_q[in_qidx];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          if (in_fail) begin
            state_d = BK_FAIL;
          end else if (cmd_i.kind == OP_PUT) begin
            state_d = BK_PUT;
          end else begin
            state_d = BK_GET_LINK;
          end
        end
      end
      BK_GET_LINK: state_d = BK_GET_DONE;
      BK_PUT, BK_GET_DONE, BK_FAIL: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    link_re     = 1'b0;
    link_raddr  = free_head_q;
    link_we     = 1'b0;
    link_waddr  = qtail_rd_q;
    link_wdata  = alloc_node;
    word_re     = 1'b0;
    word_raddr  = qhead_rd_q;
    word_we     = 1'b0;
    word_waddr  = alloc_node;
    q_re        = 1'b0;
    qhead_we    = 1'b0;
    qhead_wdata = alloc_node;
    qtail_we    = 1'b0;
    emit        = 1'b0;
    out_ok_d    = out_ok_q;
    out_word_d  = out_word_q;
    free_head_d = free_head_q;
    free_cnt_d  = free_cnt_q;
    fresh_cnt_d = fresh_cnt_q;
    qvalid_d    = qvalid_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          q_re    = 1'b1;
          link_re = 1'b1;
        end
      end
      BK_PUT: begin
        if (out_free) begin
          emit       = 1'b1;
          out_ok_d   = 1'b1;
          out_word_d = '0;
          word_we    = 1'b1;
          qtail_we   = 1'b1;
          qvalid_d[cur_qidx] = 1'b1;
          if (qvalid_q[cur_qidx]) begin
            link_we  = 1'b1;
          end else begin
            qhead_we = 1'b1;
          end
          if (free_cnt_q != '0) begin
            free_head_d = link_rd_q;
            free_cnt_d  = free_cnt_q - CntW'(1);
          end else begin
            fresh_cnt_d = fresh_cnt_q + CntW'(1);
          end
        end
      end
      BK_GET_LINK: begin
        link_re    = 1'b1;
        link_raddr = qhead_rd_q;
        word_re    = 1'b1;
      end
      BK_GET_DONE: begin
        if (out_free) begin
          emit        = 1'b1;
          out_ok_d    = 1'b1;
          out_word_d  = word_rd_q;
          link_we     = 1'b1;
          link_waddr  = qhead_rd_q;
          link_wdata  = free_head_q;
          free_head_d = qhead_rd_q;
          free_cnt_d  = free_cnt_q + CntW'(1);
          if (qhead_rd_q == qtail_rd_q) begin
            qvalid_d[cur_qidx] = 1'b0;
          end else begin
            qhead_we    = 1'b1;
            qhead_wdata = link_rd_q;
          end
        end
      end
      BK_FAIL: begin
        if (out_free) begin
          emit       = 1'b1;
          out_ok_d   = 1'b0;
          out_word_d = '0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      free_head_q <= '0;
      free_cnt_q  <= '0;
      fresh_cnt_q <= '0;
      qvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      free_cnt_q  <= free_cnt_d;
      fresh_cnt_q <= fresh_cnt_d;
      qvalid_q    <= qvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q <= cmd_i;
    end
    out_ok_q   <= out_ok_d;
    out_word_q <= out_word_d;
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[word_waddr] <= cmd_q.data_word;
    end
    if (word_re) begin
      word_rd_q <= word_mem[word_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (qhead_we) begin
      qhead_mem[cur_qidx] <= qhead_wdata;
    end
    if (q_re) begin
      qhead_rd_q <= qhead_mem[in_qidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (qtail_we) begin
      qtail_mem[cur_qidx] <= alloc_node;
    end
    if (q_re) begin
      qtail_rd_q <= qtail_mem[in_qidx];
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.ok        = out_ok_q;
  assign rsp_o.read_word = out_word_q;

endmodule

// ----- rtl/core/shared_pool_multi_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Shared pool multi queue unit
// A put passes through the back-end states idle and put, a get through idle,
// get-link and get-done, set by the registered reads of the link and word
// memories; a failed request passes through idle and fail. The last state
// waits while the response register is held. Up to two requests queue ahead
// of the back end.
// Reset is immediate: freed nodes are reused first, others come from a
// fresh-node counter, so the memories need no clearing pass.
// ----------------------------------------------------------------------------
module shared_pool_multi_queue_unit import spmq_pkg::*; #(
  parameter int unsigned POOL_NODES  = POOL_NODES_DEF,
  parameter int unsigned QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  spmq_req_if.sink   req_i,
  spmq_rsp_if.source rsp_o
);

  logic      cmd_valid;
  logic      cmd_pop;
  spmq_cmd_t cmd;

  spmq_front #(
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  spmq_back #(
    .POOL_NODES  (POOL_NODES),
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- rtl/core/spmq_checker.sv -----
// ----------------------------------------------------------------------------
// Shared pool multi queue checker
// Port-level checks on the request and response beats of the unit.
// ----------------------------------------------------------------------------
`include "shared_pool_multi_queue_unit_macros.svh"

module spmq_checker import spmq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid_i,
  input logic              req_ready_i,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic              rsp_ok_i,
  input logic [WORD_W-1:0] rsp_read_word_i
);

  localparam int unsigned OutW = $clog2(MAX_OUTSTANDING + 2);

  logic [OutW-1:0] pending_q, pending_d;
  logic            req_beat;
  logic            rsp_beat;

  assign req_beat = req_valid_i && req_ready_i;
  assign rsp_beat = rsp_valid_i && rsp_ready_i;

  always_comb begin
    pending_d = pending_q;
    if (req_beat && !rsp_beat) begin
      pending_d = pending_q + OutW'(1);
    end else if (rsp_beat && !req_beat) begin
      pending_d = pending_q - OutW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  `SPMQ_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_ok_i) && $stable(rsp_read_word_i), "response changed while stalled")
  `SPMQ_ASSERT(a_fail_zero, rsp_valid_i && !rsp_ok_i |-> rsp_read_word_i == '0, "failed response carries a word")
  `SPMQ_ASSERT(a_no_orphan, rsp_valid_i |-> pending_q != '0, "response without a pending request")
  `SPMQ_ASSERT(a_bound, pending_q <= OutW'(MAX_OUTSTANDING), "too many requests in flight")

endmodule

bind shared_pool_multi_queue_unit spmq_checker u_spmq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_ok_i        (rsp_o.ok),
  .rsp_read_word_i (rsp_o.read_word)
);
